// File: sv/sva_pkg.sv
package sva_pkg;

    localparam int OP_W     = 2;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int QUERY_W  = 10;
    localparam int STATUS_W = 2;

    localparam int ENTRIES_DEF       = 256;
    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int MAX_SNAPSHOTS_DEF = 1024;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_SNAP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_range;
        logic            row_ok;
    } t_item_ctl;

endpackage

// File: sv/sva_row_mem.sv
module sva_row_mem #(
    parameter int ELEMS = 256,
    parameter int ROW_W = 8,
    parameter int IDX_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [ROW_W-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [ROW_W-1:0] i_wr_data
);

    logic [ROW_W-1:0] mem [ELEMS];
    logic [ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/sva_rowop.sv
module sva_rowop #(
    parameter int HISTORY_DEPTH = 8,
    parameter int TAG_W         = 10,
    parameter int CNT_W         = 4,
    parameter int ROW_W         = 340
) (
    input  sva_pkg::t_item_ctl                  i_ctl,
    input  logic [ROW_W-1:0]                    i_row,
    input  logic [TAG_W-1:0]                    i_snap,
    input  logic signed [sva_pkg::VALUE_W-1:0]  i_write_value,
    input  logic [sva_pkg::QUERY_W-1:0]         i_query,
    output logic [ROW_W-1:0]                    o_row,
    output logic                                o_wr_en,
    output logic                                o_full,
    output logic signed [sva_pkg::VALUE_W-1:0]  o_read_value
);
    import sva_pkg::*;

    localparam int PAIR_W = TAG_W + VALUE_W;
    localparam int CMP_W  = (TAG_W > QUERY_W) ? TAG_W : QUERY_W;

    logic [CNT_W-1:0]                      cnt;
    logic [CNT_W-1:0]                      cnt_n;
    logic [HISTORY_DEPTH-1:0][TAG_W-1:0]   tags;
    logic [HISTORY_DEPTH-1:0][VALUE_W-1:0] vals;
    logic [HISTORY_DEPTH-1:0][TAG_W-1:0]   tags_n;
    logic [HISTORY_DEPTH-1:0][VALUE_W-1:0] vals_n;
    logic [TAG_W-1:0]                      last_tag;
    logic                                  ovw;
    logic                                  app;
    logic                                  is_write;
    logic                                  is_read;
    logic [HISTORY_DEPTH:0]                hit;
    logic [CMP_W-1:0]                      query_ext;
    logic [VALUE_W-1:0]                    found;

    always_comb begin
        cnt = i_ctl.row_ok ? i_row[ROW_W-1 -: CNT_W] : '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            tags[k] = i_row[k*PAIR_W+VALUE_W +: TAG_W];
            vals[k] = i_row[k*PAIR_W +: VALUE_W];
        end
    end

    // write: overwrite newest pair when it carries the current tag, else append if room remains
    always_comb begin
        is_write = (i_ctl.op == OP_WRITE) && i_ctl.in_range;
        last_tag = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            if (CNT_W'(k + 1) == cnt) begin
                last_tag = tags[k];
            end
        end
        ovw    = (cnt != '0) && (last_tag == i_snap);
        app    = !ovw && (cnt < CNT_W'(HISTORY_DEPTH));
        tags_n = tags;
        vals_n = vals;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            if (ovw && (CNT_W'(k + 1) == cnt)) begin
                vals_n[k] = i_write_value;
            end
            if (app && (CNT_W'(k) == cnt)) begin
                tags_n[k] = i_snap;
                vals_n[k] = i_write_value;
            end
        end
        cnt_n = app ? cnt + CNT_W'(1) : cnt;
        o_row[ROW_W-1 -: CNT_W] = cnt_n;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            o_row[k*PAIR_W +: PAIR_W] = {tags_n[k], vals_n[k]};
        end
        o_wr_en = is_write && (ovw || app);
        o_full  = is_write && !ovw && !app;
    end

    // tags ascend, so hits form a prefix; the last hit is the newest match
    always_comb begin
        is_read   = (i_ctl.op == OP_READ) && i_ctl.in_range;
        query_ext = CMP_W'(i_query);
        hit       = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            hit[k] = (CNT_W'(k) < cnt) && (CMP_W'(tags[k]) <= query_ext);
        end
        found = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            if (hit[k] && !hit[k+1]) begin
                found = found | vals[k];
            end
        end
        o_read_value = is_read ? $signed(found) : '0;
    end

endmodule

// File: sv/snapshot_versioned_array.sv
// channel | valid   | stall   | payload
// --------+---------+---------+--------------------------------------------------
// in      | i_valid | o_stall | i_opcode i_index i_write_value i_query_snapshot
// out     | o_valid | i_stall | o_read_value o_taken_snapshot o_status
//
// The row memory read is registered when a word is taken; the compare and
// write-back of that row follow. A stalled result holds the word in flight.
// Reset (synchronous, i_rst_n low) clears the per-element valid bits and the
// snapshot counter; history rows are undefined until written.
// o_stall is high while a word is in flight; a new word is taken while a
// finished result still waits on the output.
module snapshot_versioned_array #(
    parameter int ENTRIES       = sva_pkg::ENTRIES_DEF,
    parameter int HISTORY_DEPTH = sva_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_SNAPSHOTS = sva_pkg::MAX_SNAPSHOTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [sva_pkg::OP_W-1:0]              i_opcode,
    input  logic [sva_pkg::INDEX_W-1:0]           i_index,
    input  logic signed [sva_pkg::VALUE_W-1:0]    i_write_value,
    input  logic [sva_pkg::QUERY_W-1:0]           i_query_snapshot,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [sva_pkg::VALUE_W-1:0]    o_read_value,
    output logic [sva_pkg::QUERY_W-1:0]           o_taken_snapshot,
    output logic [sva_pkg::STATUS_W-1:0]          o_status
);
    import sva_pkg::*;

    localparam int ADDRS  = 1 << INDEX_W;
    localparam int ELEMS  = (ENTRIES < ADDRS) ? ENTRIES : ADDRS;
    localparam int IDX_W  = (ELEMS > 1) ? $clog2(ELEMS) : 1;
    localparam int TAG_W  = $clog2(MAX_SNAPSHOTS);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int ROW_W  = CNT_W + HISTORY_DEPTH * (TAG_W + VALUE_W);
    localparam int SNAP_W = (TAG_W > QUERY_W) ? TAG_W : QUERY_W;
    localparam logic [TAG_W-1:0] SNAP_LAST = TAG_W'(MAX_SNAPSHOTS - 1);

    logic                       accept;
    logic                       done;
    logic                       in_range;
    logic [IDX_W-1:0]           idx;
    logic [ROW_W-1:0]           rd_row;
    logic [ROW_W-1:0]           wr_row;
    logic                       wr_en;
    logic                       full;
    logic signed [VALUE_W-1:0]  rd_value;
    logic                       snap_limit;
    logic [SNAP_W-1:0]          snap_ext;
    t_item_ctl                  ctl;

    logic                       r_busy;
    logic [OP_W-1:0]            r_op;
    logic                       r_in_range;
    logic                       r_row_ok;
    logic [IDX_W-1:0]           r_idx;
    logic signed [VALUE_W-1:0]  r_wval;
    logic [QUERY_W-1:0]         r_query;
    logic [TAG_W-1:0]           r_snap;
    logic [ELEMS-1:0]           r_row_valid;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_out_value;
    logic [QUERY_W-1:0]         r_out_taken;
    logic [STATUS_W-1:0]        r_out_status;

    assign idx        = i_index[IDX_W-1:0];
    assign in_range   = 32'(i_index) < ENTRIES;
    assign accept     = i_valid && !r_busy;
    assign done       = r_busy && (!r_out_valid || !i_stall);
    assign snap_limit = (r_snap == SNAP_LAST);
    assign snap_ext   = SNAP_W'(r_snap);

    assign ctl.op       = r_op;
    assign ctl.in_range = r_in_range;
    assign ctl.row_ok   = r_row_ok;

    sva_row_mem #(
        .ELEMS (ELEMS),
        .ROW_W (ROW_W),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (idx),
        .o_rd_data (rd_row),
        .i_wr_en   (done && wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (wr_row)
    );

    sva_rowop #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TAG_W         (TAG_W),
        .CNT_W         (CNT_W),
        .ROW_W         (ROW_W)
    ) u_rowop (
        .i_ctl         (ctl),
        .i_row         (rd_row),
        .i_snap        (r_snap),
        .i_write_value (r_wval),
        .i_query       (r_query),
        .o_row         (wr_row),
        .o_wr_en       (wr_en),
        .o_full        (full),
        .o_read_value  (rd_value)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_opcode;
            r_in_range <= in_range;
            r_row_ok   <= in_range && r_row_valid[idx];
            r_idx      <= idx;
            r_wval     <= i_write_value;
            r_query    <= i_query_snapshot;
        end
        if (done) begin
            r_out_value  <= rd_value;
            r_out_taken  <= (r_op == OP_SNAP) ? snap_ext[QUERY_W-1:0] : '0;
            if (full) begin
                r_out_status <= ST_FULL;
            end else if (r_op == OP_SNAP && snap_limit) begin
                r_out_status <= ST_LIMIT;
            end else begin
                r_out_status <= ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_snap      <= '0;
            r_row_valid <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (done && r_op == OP_SNAP && !snap_limit) begin
                r_snap <= r_snap + TAG_W'(1);
            end
            if (done && wr_en) begin
                r_row_valid[r_idx] <= 1'b1;
            end
        end
    end

    assign o_stall          = r_busy;
    assign o_valid          = r_out_valid;
    assign o_read_value     = r_out_value;
    assign o_taken_snapshot = r_out_taken;
    assign o_status         = r_out_status;

    a_snap_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_op == OP_SNAP && !snap_limit) |=> (r_snap == $past(r_snap) + TAG_W'(1)))
        else $error("snapshot counter did not advance");

    a_wb_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && wr_en) |-> (r_op == OP_WRITE && r_in_range))
        else $error("row write-back outside a write word");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_read_value == 0))
        else $error("flagged result carries read data");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && !done) || (r_busy && done))
        else $error("accepted word not in flight");

endmodule
